/* design/starfield_projection_engine_defines.svh */
// assertion macros for the starfield projection engine
`ifndef STARFIELD_PROJECTION_ENGINE_DEFINES_SVH
`define STARFIELD_PROJECTION_ENGINE_DEFINES_SVH
// property a implies b in the next cycle
`define SPE_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// property a implies b in the same cycle
`define SPE_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

/* design/spe_pkg.sv */
// ---------------------------------------------------------------------------
// spe_pkg
// types and constants shared by the starfield projection engine
// ---------------------------------------------------------------------------
package spe_pkg;
    localparam int SCR_W = 240;
    localparam int SCR_H = 135;
    localparam int CX = 160;
    localparam int CY = 120;

    localparam logic [1:0] REG_SEED_A = 2'd0;
    localparam logic [1:0] REG_SEED_B = 2'd1;
    localparam logic [1:0] REG_SEED_C = 2'd2;
    localparam logic [1:0] REG_SEED_CNT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_DIV_RUN,
        ST_ERASE,
        ST_DRAW,
        ST_OUT
    } state_t;
endpackage

/* design/spe_ram.sv */
// ---------------------------------------------------------------------------
// spe_ram
// single port synchronous ram with registered read
// ---------------------------------------------------------------------------
module spe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* design/starfield_projection_engine.sv */
// ---------------------------------------------------------------------------
// starfield_projection_engine
// updates one star per input item, emits erase and draw pixel items
// ---------------------------------------------------------------------------
// usage: s_axis carries star_index; m_axis carries pixel commands
// {pixel_color, pixel_y, pixel_x} in tdata and is_last in tlast.
// config: cfg_we/cfg_index/cfg_data load generator seeds at once.
// after reset the star memory is cleared by a sweep over all STAR_COUNT
// words, during which s_axis_tready stays low.
// each star is read from one x/y/depth memory word (registered read),
// then up to four 16-step divisions run on one shared restoring divider.
// a new index is accepted only in idle, once the previous star is done;
// a star that is erased and drawn gives its erase item before its draw item.
// results are held in an output register; while the receiver stalls the
// block waits with the result and accepts no new item.
// respawn and out-of-range indexes give no output item.
// ---------------------------------------------------------------------------
module starfield_projection_engine #(
    parameter int STAR_COUNT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // star_index[9:0], zero fill
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [31:0] m_axis_tdata,   // pixel_x[7:0], pixel_y[15:8], pixel_color[31:16]
    output logic        m_axis_tlast,   // is_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

    spe_pkg::state_t state_reg, state_next;

    logic          clr_reg;
    logic [AW:0]   clr_cnt_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]    gen_a_reg, gen_b_reg, gen_c_reg, gen_cnt_reg, spawn_reg;
    logic [7:0]    sx_reg, sy_reg, z_reg;
    logic          phase_reg;   // 0 erase, 1 draw
    logic          axis_reg;    // 0 x, 1 y
    logic [15:0]   dvd_reg;     // magnitude of numerator
    logic [7:0]    rem_reg;
    logic [8:0]    rem9;
    logic [4:0]    dcnt_reg;
    logic          neg_reg;
    logic signed [10:0] px_reg;
    logic          ovalid_reg;
    logic [31:0]   odata_reg;
    logic          olast_reg;
    logic          pend_reg;    // erase item waiting
    logic [31:0]   pdata_reg;
    logic          draw_reg;    // draw item waiting
    logic [31:0]   ddata_reg;

    logic [23:0]   rd;
    logic          we;
    logic [AW-1:0] addr;
    logic [23:0]   wd;

    spe_ram #(.WIDTH(24), .DEPTH(STAR_COUNT)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wd), .rdata(rd)
    );

    wire [9:0] in_idx = s_axis_tdata[9:0];
    wire [AW-1:0] in_addr = AW'(in_idx);
    wire accept = s_axis_tvalid && s_axis_tready;
    wire in_range = {22'd0, in_idx} < STAR_COUNT;

    // generator steps
    logic [7:0] c1, a1, b1, c2, a2, b2, n1, n2;
    always_comb
    begin
        n1 = gen_cnt_reg + 8'd1;
        a1 = gen_a_reg ^ gen_c_reg ^ n1;
        b1 = gen_b_reg + a1;
        c1 = (gen_c_reg + {1'b0, b1[7:1]}) ^ a1;
        n2 = n1 + 8'd1;
        a2 = a1 ^ c1 ^ n2;
        b2 = b1 + a2;
        c2 = (c1 + {1'b0, b2[7:1]}) ^ a2;
    end

    wire [7:0] zcur = phase_reg ? (z_reg - 8'd2) : z_reg;
    wire signed [9:0] numc = axis_reg ? ($signed({2'b0, sy_reg}) - 10'sd120)
                                      : ($signed({2'b0, sx_reg}) - 10'sd160);
    wire [8:0] nmag = numc[9] ? 9'(-numc) : 9'(numc);
    assign rem9 = {rem_reg, dvd_reg[15]};
    // quotient magnitude fits 16 bits; far points are clamped off screen below
    logic [15:0] qfull_reg;
    wire signed [17:0] qsv = neg_reg ? -$signed({2'b0, qfull_reg}) : $signed({2'b0, qfull_reg});
    wire signed [17:0] pv = qsv + (axis_reg ? 18'sd120 : 18'sd160);
    wire signed [10:0] pclip = (pv > 18'sd300 || pv < -18'sd300) ? 11'sd1000 : pv[10:0];
    wire onscr = (px_reg >= 0) && (px_reg < spe_pkg::SCR_W)
              && (pclip >= 0) && (pclip < spe_pkg::SCR_H);
    wire [7:0] g = 8'd255 - zcur;
    wire [15:0] col = {g[7:3], g[7:2], g[7:3]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spe_pkg::ST_IDLE:    if (accept && in_range) state_next = spe_pkg::ST_READ;
            spe_pkg::ST_READ:    state_next = spe_pkg::ST_CHECK;
            spe_pkg::ST_CHECK:   state_next = (rd[23:16] <= 8'd1) ? spe_pkg::ST_IDLE
                                                                  : spe_pkg::ST_DIV;
            spe_pkg::ST_DIV:     state_next = spe_pkg::ST_DIV_RUN;
            spe_pkg::ST_DIV_RUN:
                if (dcnt_reg == 5'd0)
                    state_next = axis_reg ? (phase_reg ? spe_pkg::ST_DRAW : spe_pkg::ST_ERASE)
                                          : spe_pkg::ST_DIV;
            spe_pkg::ST_ERASE:
                state_next = ((z_reg - 8'd2) > 8'd1) ? spe_pkg::ST_DIV : spe_pkg::ST_OUT;
            spe_pkg::ST_DRAW:    state_next = spe_pkg::ST_OUT;
            spe_pkg::ST_OUT:
                // with both items the erase goes first, then the draw
                if (!ovalid_reg && !(pend_reg && draw_reg))
                    state_next = spe_pkg::ST_IDLE;
            default:             state_next = spe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == spe_pkg::ST_IDLE) && !clr_reg && !ovalid_reg;
        we = 1'b0;
        addr = idx_reg;
        wd = {z_reg, sy_reg, sx_reg};
        if (clr_reg)
        begin
            we = 1'b1;
            addr = clr_cnt_reg[AW-1:0];
            wd = '0;
        end
        else if (state_reg == spe_pkg::ST_IDLE)
        begin
            addr = in_addr;
        end
        else if (state_reg == spe_pkg::ST_CHECK && rd[23:16] <= 8'd1)
        begin
            we = 1'b1;
            wd = {spawn_reg, c2, c1 + 8'd40};
        end
        else if (state_reg == spe_pkg::ST_ERASE && (z_reg - 8'd2) <= 8'd1)
        begin
            we = 1'b1;
            wd = {z_reg - 8'd2, sy_reg, sx_reg};
        end
        else if (state_reg == spe_pkg::ST_DRAW)
        begin
            we = 1'b1;
            wd = {onscr ? zcur : 8'd0, sy_reg, sx_reg};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign m_axis_tlast = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spe_pkg::ST_IDLE;
            clr_reg <= 1'b1;
            clr_cnt_reg <= '0;
            gen_a_reg <= 8'd0;
            gen_b_reg <= 8'd0;
            gen_c_reg <= 8'd0;
            gen_cnt_reg <= 8'd0;
            spawn_reg <= 8'd255;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (AW+1)'(STAR_COUNT - 1))
                    clr_reg <= 1'b0;
            end
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            if (accept && in_range && in_idx == 10'd0)
                spawn_reg <= 8'd255;
            case (state_reg)
                spe_pkg::ST_CHECK:
                    if (rd[23:16] <= 8'd1)
                    begin
                        gen_cnt_reg <= n2;
                        gen_a_reg <= a2;
                        gen_b_reg <= b2;
                        gen_c_reg <= c2;
                        spawn_reg <= spawn_reg - 8'd1;
                    end
                spe_pkg::ST_OUT:
                    if (!ovalid_reg && (pend_reg || draw_reg))
                    begin
                        ovalid_reg <= 1'b1;
                    end
                default: ;
            endcase
            if (cfg_we)
            begin
                case (cfg_index)
                    spe_pkg::REG_SEED_A:   gen_a_reg <= cfg_data;
                    spe_pkg::REG_SEED_B:   gen_b_reg <= cfg_data;
                    spe_pkg::REG_SEED_C:   gen_c_reg <= cfg_data;
                    spe_pkg::REG_SEED_CNT: gen_cnt_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // pending items: erase waits while draw is computed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            draw_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == spe_pkg::ST_ERASE)
            begin
                pend_reg <= onscr;
                draw_reg <= 1'b0;
            end
            if (state_reg == spe_pkg::ST_DRAW)
                draw_reg <= onscr;
            if (state_reg == spe_pkg::ST_OUT && !ovalid_reg)
            begin
                if (pend_reg)
                    pend_reg <= 1'b0;
                else
                    draw_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            spe_pkg::ST_IDLE:
            begin
                idx_reg <= in_addr;
            end
            spe_pkg::ST_CHECK:
            begin
                sx_reg <= rd[7:0];
                sy_reg <= rd[15:8];
                z_reg <= rd[23:16];
                phase_reg <= 1'b0;
                axis_reg <= 1'b0;
            end
            spe_pkg::ST_DIV:
            begin
                dvd_reg <= {nmag[7:0], 8'd0};
                rem_reg <= {7'd0, nmag[8]};
                neg_reg <= numc[9];
                dcnt_reg <= 5'd16;
                qfull_reg <= 16'd0;
            end
            spe_pkg::ST_DIV_RUN:
            begin
                if (dcnt_reg != 5'd0)
                begin
                    dcnt_reg <= dcnt_reg - 5'd1;
                    dvd_reg <= {dvd_reg[14:0], 1'b0};
                    if ({rem_reg, dvd_reg[15]} >= {1'b0, zcur})
                    begin
                        rem_reg <= 8'({rem_reg, dvd_reg[15]} - {1'b0, zcur});
                        qfull_reg <= {qfull_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem9[7:0];
                        qfull_reg <= {qfull_reg[14:0], 1'b0};
                    end
                end
                else if (!axis_reg)
                begin
                    // x done, y next
                    px_reg <= pclip;
                    axis_reg <= 1'b1;
                end
            end
            spe_pkg::ST_ERASE:
            begin
                pdata_reg <= {16'd0, pclip[7:0], px_reg[7:0]};
                phase_reg <= 1'b1;
                axis_reg <= 1'b0;
                z_reg <= z_reg;
            end
            spe_pkg::ST_DRAW:
            begin
                ddata_reg <= {col, pclip[7:0], px_reg[7:0]};
            end
            default: ;
        endcase
        if (state_reg == spe_pkg::ST_OUT && !ovalid_reg)
        begin
            if (pend_reg)
            begin
                odata_reg <= pdata_reg;
                olast_reg <= !draw_reg;
            end
            else
            begin
                odata_reg <= ddata_reg;
                olast_reg <= 1'b1;
            end
        end
    end

    logic unused;
    assign unused = ^{s_axis_tdata[15:10]};
endmodule

/* design/spe_checker.sv */
// ---------------------------------------------------------------------------
// spe_checker
// port level checks on the starfield projection engine
// ---------------------------------------------------------------------------
`include "starfield_projection_engine_defines.svh"
module spe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `SPE_ASSERT_NEXT(hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SPE_ASSERT_NEXT(hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `SPE_ASSERT_NOW(x_range, m_axis_tvalid, m_axis_tdata[7:0] < 8'd240)
    `SPE_ASSERT_NOW(y_range, m_axis_tvalid, m_axis_tdata[15:8] < 8'd135)
    `SPE_ASSERT_NEXT(no_take_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind starfield_projection_engine spe_checker u_spe_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// starfield projection engine testbench
// drives star indexes over the input stream and checks every pixel item
// against a behavioral copy of the starfield, its generator and spawn counter
// ---------------------------------------------------------------------------
module testbench;
    localparam int NSTARS = 1024;

    typedef struct packed {
        logic [7:0]  px;
        logic [7:0]  py;
        logic [15:0] color;
        logic        last;
    } pixel_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // shadow starfield
    logic [7:0] sky_x [NSTARS];
    logic [7:0] sky_y [NSTARS];
    logic [7:0] sky_z [NSTARS];
    logic [7:0] rng_a, rng_b, rng_c, rng_cnt;
    logic [7:0] next_spawn;

    pixel_cmd_t pending_pixels[$];
    int errors;
    int stars_sent;
    int pixels_seen;
    int burst_left;
    int stall_mode;

    starfield_projection_engine #(.STAR_COUNT(NSTARS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [7:0] rng_step();
        rng_cnt = rng_cnt + 8'd1;
        rng_a   = rng_a ^ rng_c ^ rng_cnt;
        rng_b   = rng_b + rng_a;
        rng_c   = (rng_c + (rng_b >> 1)) ^ rng_a;
        return rng_c;
    endfunction

    function automatic int perspective(logic [7:0] coord, int centre, logic [7:0] z);
        int num;
        num = (int'(coord) - centre) * 256;
        return num / int'(z) + centre;
    endfunction

    function automatic bit visible(int x, int y);
        return x >= 0 && y >= 0 && x < spe_pkg::SCR_W && y < spe_pkg::SCR_H;
    endfunction

    // update the shadow star and queue the pixel items it causes
    task automatic predict_star(int idx);
        logic [7:0] z;
        logic [7:0] g;
        int x, y, n;
        pixel_cmd_t cmd;
        n = 0;
        if (idx == 0)
            next_spawn = 8'd255;
        z = sky_z[idx];
        if (z <= 1)
        begin
            sky_x[idx] = 8'd40 + rng_step();
            sky_y[idx] = rng_step();
            sky_z[idx] = next_spawn;
            next_spawn = next_spawn - 8'd1;
        end
        else
        begin
            x = perspective(sky_x[idx], spe_pkg::CX, z);
            y = perspective(sky_y[idx], spe_pkg::CY, z);
            if (visible(x, y))
            begin
                cmd = '{px: x[7:0], py: y[7:0], color: 16'd0, last: 1'b0};
                pending_pixels.push_back(cmd);
                n++;
            end
            z = z - 8'd2;
            sky_z[idx] = z;
            if (z > 1)
            begin
                x = perspective(sky_x[idx], spe_pkg::CX, z);
                y = perspective(sky_y[idx], spe_pkg::CY, z);
                if (visible(x, y))
                begin
                    g = 8'd255 - z;
                    cmd.px = x[7:0];
                    cmd.py = y[7:0];
                    cmd.color = {g[7:3], g[7:2], g[7:3]};
                    cmd.last = 1'b0;
                    pending_pixels.push_back(cmd);
                    n++;
                end
                else
                    sky_z[idx] = 8'd0;
            end
            if (n > 0)
                pending_pixels[pending_pixels.size() - 1].last = 1'b1;
        end
    endtask

    // one star index, sent in bursts with random gaps
    task automatic send_star(int idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, idx[9:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_star(idx);
        stars_sent++;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_seed(logic [1:0] reg_id, logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_id;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (reg_id)
            spe_pkg::REG_SEED_A:   rng_a = value;
            spe_pkg::REG_SEED_B:   rng_b = value;
            spe_pkg::REG_SEED_C:   rng_c = value;
            spe_pkg::REG_SEED_CNT: rng_cnt = value;
            default: ;
        endcase
    endtask

    // respawns give no item, so allow the block to finish its last star too
    task automatic drain();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic load_seeds(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] n);
        drain();
        write_seed(spe_pkg::REG_SEED_A, a);
        write_seed(spe_pkg::REG_SEED_B, b);
        write_seed(spe_pkg::REG_SEED_C, c);
        write_seed(spe_pkg::REG_SEED_CNT, n);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pixel_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            pixels_seen++;
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.px)
                    report_mismatch("pixel_x", m_axis_tdata[7:0], want.px);
                if (m_axis_tdata[15:8] !== want.py)
                    report_mismatch("pixel_y", m_axis_tdata[15:8], want.py);
                if (m_axis_tdata[31:16] !== want.color)
                    report_mismatch("pixel_color", m_axis_tdata[31:16], want.color);
                if (m_axis_tlast !== want.last)
                    report_mismatch("is_last", m_axis_tlast, want.last);
            end
        end
    end

    // receiver stall pattern, mode changes every so often
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 19) == 0);
        endcase
    end

    task automatic test_directed();
        int picks[] = '{0, 1023, 512, 1, 0, 1023, 512, 1, 341, 682, 0, 1023,
                        512, 1, 341, 682, 0, 1023, 512, 1};
        foreach (picks[i])
            send_star(picks[i]);
    endtask

    // one star stepped from spawn through its whole life, several times
    task automatic test_star_lifetime();
        repeat (150) send_star(3);
    endtask

    // mostly a small pool so stars age, with some far indexes and frame restarts
    task automatic test_random_stars(int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                send_star($urandom_range(0, 15));
            else if (r == 7)
                send_star(0);
            else
                send_star($urandom_range(0, NSTARS - 1));
        end
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = spe_pkg::REG_SEED_A;
        cfg_data = '0;
        errors = 0;
        stars_sent = 0;
        pixels_seen = 0;
        burst_left = 0;
        stall_mode = 0;
        for (k = 0; k < NSTARS; k++)
        begin
            sky_x[k] = 8'd0;
            sky_y[k] = 8'd0;
            sky_z[k] = 8'd0;
        end
        rng_a = 8'd0;
        rng_b = 8'd0;
        rng_c = 8'd0;
        rng_cnt = 8'd0;
        next_spawn = 8'd255;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_directed();
        test_random_stars(150);
        load_seeds(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        test_star_lifetime();
        test_random_stars(150);
        load_seeds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        test_random_stars(150);
        load_seeds(8'h00, 8'h00, 8'h00, 8'h00);
        test_random_stars(100);
        drain();

        $display("sent %0d star updates, checked %0d pixel items", stars_sent, pixels_seen);
        $display("seed settings: reset, all ones, random, all zero");
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
